// ----- design/swmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

  localparam int DATA_W         = 32;
  localparam int WS_W           = 7;
  localparam int MAX_WINDOW_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } minmax_t;

endpackage

`default_nettype wire

// ----- design/swmm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swmm_cell #(
  parameter int CNT_W = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift_en,
  input  logic signed [swmm_pkg::DATA_W-1:0]  sample_in,
  output logic signed [swmm_pkg::DATA_W-1:0]  sample_out,
  input  logic                                tok_in_valid,
  input  swmm_pkg::minmax_t                   tok_in,
  input  logic [CNT_W-1:0]                    tok_in_left,
  output logic                                tok_out_valid,
  output swmm_pkg::minmax_t                   tok_out,
  output logic [CNT_W-1:0]                    tok_out_left,
  input  logic                                emit_ok,
  output logic                                emit_valid,
  output swmm_pkg::minmax_t                   emit_val
);

  logic signed [swmm_pkg::DATA_W-1:0] stored;
  logic signed [swmm_pkg::DATA_W-1:0] cmp;
  logic                               tok_valid;
  logic                               tok_valid_next;
  swmm_pkg::minmax_t                  tok;
  swmm_pkg::minmax_t                  tok_next;
  logic [CNT_W-1:0]                   left;

  assign cmp = shift_en ? sample_in : stored;

  always_comb begin
    tok_next.lo = (cmp < tok_in.lo) ? cmp : tok_in.lo;
    tok_next.hi = (cmp > tok_in.hi) ? cmp : tok_in.hi;
  end

  assign emit_valid    = tok_valid && (left == '0);
  assign emit_val      = emit_valid ? tok : '0;
  assign tok_out_valid = tok_valid && (left != '0);
  assign tok_out       = tok;
  assign tok_out_left  = left - CNT_W'(1);
  assign sample_out    = stored;

  always_comb begin
    if (tok_in_valid) begin
      tok_valid_next = 1'b1;
    end else begin
      tok_valid_next = emit_valid && !emit_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      stored <= sample_in;
    end
    if (tok_in_valid) begin
      tok  <= tok_next;
      left <= tok_in_left;
    end
  end

endmodule

`default_nettype wire

// ----- design/sliding_window_min_max_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_stall    sample, last_sample
// out      out_valid / out_stall  window_min, window_max, last_window
// cfg      cfg_valid / cfg_ready  window_size
//
// A sample that yields a result starts a min/max request that walks one cell per cycle
// down the history chain to the cell at depth W, W being the effective window; when it
// leaves that cell the result is loaded into the output register and the input reopens.
// A sample that yields nothing does not stall the input.
// Reset clears the fill count, the in-flight request and the output valid flag.
// A stalled output holds the request in its final cell and keeps the input stalled.

module sliding_window_min_max_core #(
  parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [swmm_pkg::DATA_W-1:0]  sample,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swmm_pkg::DATA_W-1:0]  window_min,
  output logic signed [swmm_pkg::DATA_W-1:0]  window_max,
  output logic                                last_window,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swmm_pkg::WS_W-1:0]           window_size
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int EW    = (CNT_W > swmm_pkg::WS_W) ? CNT_W : swmm_pkg::WS_W;

  logic [swmm_pkg::WS_W-1:0] ws;
  logic [EW-1:0]             ws_ext;
  logic [CNT_W-1:0]          eff;
  logic [CNT_W-1:0]          fill;
  logic [CNT_W-1:0]          fill_next;
  logic                      busy;
  logic                      busy_next;
  logic                      last_pend;
  logic                      accept;
  logic                      produce;
  logic                      inject;
  logic                      emit_ok;
  logic                      emit_any;
  swmm_pkg::minmax_t         emit_sum;
  swmm_pkg::minmax_t         inj_val;

  logic signed [swmm_pkg::DATA_W-1:0] chain_smp [0:MAX_WINDOW];
  logic                               chain_v   [0:MAX_WINDOW];
  swmm_pkg::minmax_t                  chain_tok [0:MAX_WINDOW];
  logic [CNT_W-1:0]                   chain_lft [0:MAX_WINDOW];
  logic [MAX_WINDOW-1:0]              emit_vec;
  swmm_pkg::minmax_t                  emit_arr  [0:MAX_WINDOW-1];

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;
  assign emit_ok   = !out_valid || !out_stall;

  always_comb begin
    ws_ext = EW'(ws);
    if (ws_ext == '0) begin
      eff = CNT_W'(1);
    end else if (ws_ext > EW'(MAX_WINDOW)) begin
      eff = CNT_W'(MAX_WINDOW);
    end else begin
      eff = CNT_W'(ws_ext);
    end
  end

  assign fill_next = (fill < CNT_W'(MAX_WINDOW)) ? fill + CNT_W'(1) : fill;
  assign produce   = fill_next >= eff;
  assign inject    = accept && produce;

  always_comb begin
    inj_val.lo = sample;
    inj_val.hi = sample;
  end

  assign chain_smp[0] = sample;
  assign chain_v[0]   = inject;
  assign chain_tok[0] = inj_val;
  assign chain_lft[0] = eff - CNT_W'(1);

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swmm_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .shift_en     (accept),
      .sample_in    (chain_smp[i]),
      .sample_out   (chain_smp[i+1]),
      .tok_in_valid (chain_v[i]),
      .tok_in       (chain_tok[i]),
      .tok_in_left  (chain_lft[i]),
      .tok_out_valid(chain_v[i+1]),
      .tok_out      (chain_tok[i+1]),
      .tok_out_left (chain_lft[i+1]),
      .emit_ok      (emit_ok),
      .emit_valid   (emit_vec[i]),
      .emit_val     (emit_arr[i])
    );
  end

  always_comb begin
    emit_sum = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      emit_sum = emit_sum | emit_arr[i];
    end
  end

  assign emit_any = |emit_vec;

  always_comb begin
    busy_next = busy;
    if (emit_any && emit_ok) begin
      busy_next = 1'b0;
    end
    if (inject) begin
      busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ws        <= swmm_pkg::WS_W'(1);
      fill      <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ws <= window_size;
      end
      if (accept) begin
        fill <= last_sample ? '0 : fill_next;
      end
      busy <= busy_next;
      if (emit_any && emit_ok) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inject) begin
      last_pend <= last_sample;
    end
    if (emit_any && emit_ok) begin
      window_min  <= emit_sum.lo;
      window_max  <= emit_sum.hi;
      last_window <= last_pend;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !chain_v[MAX_WINDOW])
    else $error("request ran past the end of the chain");

  a_single_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(emit_vec))
    else $error("more than one cell finishing a request");

  a_emit_only_busy: assert property (@(posedge clk) disable iff (rst)
    emit_any |-> busy)
    else $error("result emitted with no request in flight");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    (emit_any && emit_ok) |=> (out_valid && !busy))
    else $error("finished request not delivered to output");

endmodule

`default_nettype wire

// ----- sim/sliding_window_min_max_checker.sv -----
`timescale 1ns / 1ps

module sliding_window_min_max_checker #(
  parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [swmm_pkg::DATA_W-1:0]  sample,
  input  logic                                last_sample,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [swmm_pkg::DATA_W-1:0]  window_min,
  input  logic signed [swmm_pkg::DATA_W-1:0]  window_max,
  input  logic                                last_window,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [swmm_pkg::WS_W-1:0]           window_size,
  output int                                  fail_count,
  output int                                  outstanding
);

  typedef struct {
    swmm_pkg::minmax_t span;
    logic              closing;
  } window_span_t;

  logic [swmm_pkg::DATA_W-1:0] history [MAX_WINDOW];
  int unsigned                 head;
  int unsigned                 fill;
  logic [swmm_pkg::WS_W-1:0]   span_len;
  window_span_t                due_spans [$];

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic track_sample(input logic signed [swmm_pkg::DATA_W-1:0] s, input logic closing);
    int unsigned  w;
    int unsigned  idx;
    window_span_t res;
    w = (span_len == 0) ? 1 : (span_len > MAX_WINDOW) ? MAX_WINDOW : span_len;
    history[head] = s;
    head = (head + 1) % MAX_WINDOW;
    if (fill < MAX_WINDOW) begin
      fill++;
    end
    if (fill >= w) begin
      res.span.lo = s;
      res.span.hi = s;
      res.closing = closing;
      for (int i = 1; i < w; i++) begin
        idx = (head + MAX_WINDOW - 1 - i) % MAX_WINDOW;
        if ($signed(history[idx]) < res.span.lo) begin
          res.span.lo = history[idx];
        end
        if ($signed(history[idx]) > res.span.hi) begin
          res.span.hi = history[idx];
        end
      end
      due_spans.push_back(res);
    end
    if (closing) begin
      fill = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    window_span_t want;
    if (rst) begin
      head = 0;
      fill = 0;
      span_len = swmm_pkg::WS_W'(1);
      due_spans.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_spans.size() == 0) begin
          report_mismatch($sformatf("unexpected result min %0d max %0d last %0b",
                                    window_min, window_max, last_window));
        end else begin
          want = due_spans.pop_front();
          if (window_min !== want.span.lo) begin
            report_mismatch($sformatf("window_min expected %0d got %0d",
                                      want.span.lo, window_min));
          end
          if (window_max !== want.span.hi) begin
            report_mismatch($sformatf("window_max expected %0d got %0d",
                                      want.span.hi, window_max));
          end
          if (last_window !== want.closing) begin
            report_mismatch($sformatf("last_window expected %0b got %0b",
                                      want.closing, last_window));
          end
        end
      end
      if (in_valid && !in_stall) begin
        track_sample(sample, last_sample);
      end
      if (cfg_valid && cfg_ready) begin
        span_len = window_size;
      end
    end
    outstanding <= due_spans.size();
  end

endmodule

// ----- sim/sliding_window_min_max_core_test.sv -----
`timescale 1ns / 1ps

module sliding_window_min_max_core_test;

  localparam int MAX_WINDOW   = swmm_pkg::MAX_WINDOW_DEF;
  localparam int PRESS_CYCLES = 400;
  localparam int SETTLE       = MAX_WINDOW + 8;
  localparam int PHASES       = 14;

  logic                               clk         = 1'b0;
  logic                               rst         = 1'b1;
  logic                               in_valid    = 1'b0;
  logic                               in_stall;
  logic signed [swmm_pkg::DATA_W-1:0] sample      = '0;
  logic                               last_sample = 1'b0;
  logic                               out_valid;
  logic                               out_stall   = 1'b0;
  logic signed [swmm_pkg::DATA_W-1:0] window_min;
  logic signed [swmm_pkg::DATA_W-1:0] window_max;
  logic                               last_window;
  logic                               cfg_valid   = 1'b0;
  logic                               cfg_ready;
  logic [swmm_pkg::WS_W-1:0]          window_size = '0;
  int                                 fail_count;
  int                                 outstanding;

  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;
  bit press_req  = 1'b0;

  int phase_win [9] = '{1, 127, 0, 2, 64, 3, 65, 7, 1};

  sliding_window_min_max_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .window_min  (window_min),
    .window_max  (window_max),
    .last_window (last_window),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .window_size (window_size)
  );

  sliding_window_min_max_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .window_min  (window_min),
    .window_max  (window_max),
    .last_window (last_window),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .window_size (window_size),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : drain
    int unsigned run;
    bit          stalled;
    run = 0;
    stalled = 1'b0;
    forever begin
      @(posedge clk);
      if (press_req) begin
        press_req = 1'b0;
        stalled = 1'b1;
        run = PRESS_CYCLES;
      end else if (run == 0) begin
        if (sink_quiet) begin
          stalled = 1'b0;
          run = 16;
        end else begin
          stalled = ($urandom_range(0, 2) == 0);
          if (!stalled) begin
            run = $urandom_range(1, 6);
          end else if ($urandom_range(0, 9) < 9) begin
            run = $urandom_range(1, 3);
          end else begin
            run = $urandom_range(10, 60);
          end
        end
      end
      run--;
      out_stall <= stalled;
    end
  end

  task automatic push_sample(input logic [swmm_pkg::DATA_W-1:0] value, input logic closing);
    int unsigned gap;
    int unsigned r;
    in_valid <= 1'b1;
    sample <= value;
    last_sample <= closing;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = $urandom_range(0, 99);
    if (src_quiet || r < 55) begin
      gap = 0;
    end else if (r < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [swmm_pkg::WS_W-1:0] w);
    drain_wait();
    cfg_valid <= 1'b1;
    window_size <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned                 eff;
    int unsigned                 budget;
    int unsigned                 sent;
    int unsigned                 len;
    int unsigned                 r;
    logic [swmm_pkg::WS_W-1:0]   win;
    logic [swmm_pkg::DATA_W-1:0] value;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // window of one straight out of reset, field extremes
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);

    // zero acts as one
    set_window(7'd0);
    push_sample(32'd5, 1'b0);
    push_sample(-32'sd5, 1'b1);

    // short sequence yields nothing, then a full one
    set_window(7'd3);
    push_sample(32'd7, 1'b1);
    push_sample(32'd1, 1'b0);
    push_sample(32'd2, 1'b0);
    push_sample(32'd3, 1'b0);

    // shrink mid-sequence
    set_window(7'd2);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);

    // grow past the fill count, then shrink below it
    set_window(7'd5);
    push_sample(32'd10, 1'b0);
    push_sample(32'd20, 1'b0);
    set_window(7'd2);
    push_sample(32'd30, 1'b1);

    // grow mid-sequence to exactly the fill count
    push_sample(-32'sd7, 1'b0);
    push_sample(-32'sd8, 1'b0);
    push_sample(-32'sd9, 1'b0);
    set_window(7'd4);
    push_sample(32'd100, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      win = swmm_pkg::WS_W'((p < 9) ? phase_win[p] : $urandom_range(1, 20));
      set_window(win);
      eff = (win == 0) ? 1 : (win > MAX_WINDOW) ? MAX_WINDOW : win;
      budget = (eff > 32) ? 170 : 90;
      src_quiet = (p == 0) || (p % 3 == 2);
      sink_quiet = (p % 4 == 3);
      if (p == 0) begin
        press_req = 1'b1;
      end
      sent = 0;
      while (sent < budget) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          len = eff + $urandom_range(0, eff + 6);
        end else if (r < 9) begin
          len = $urandom_range(1, eff);
        end else begin
          len = $urandom_range(1, 3);
        end
        for (int k = 0; k < len && sent < budget; k++) begin
          r = $urandom_range(0, 9);
          if (r < 5) begin
            value = $urandom;
          end else if (r < 7) begin
            value = 32'($urandom_range(0, 16)) - 32'd8;
          end else begin
            case ($urandom_range(0, 4))
              0:       value = 32'h8000_0000;
              1:       value = 32'h7FFF_FFFF;
              2:       value = '0;
              3:       value = '1;
              default: value = 32'd1;
            endcase
          end
          push_sample(value, k == len - 1);
          sent++;
        end
      end
    end

    drain_wait();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
